FILE: hw/rtl/depth_layer_sort_and_slice_defines.svh
// assertion macros shared by the depth layer sort and slice rtl
`ifndef DEPTH_LAYER_SORT_AND_SLICE_DEFINES_SVH
`define DEPTH_LAYER_SORT_AND_SLICE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define DLS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define DLS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/dls_pkg.sv
package dls_pkg;

   localparam int MAX_LAYERS = 16;
   localparam int DEPTH_BITS = 24;
   localparam int COUNT_BITS = $clog2(MAX_LAYERS + 1);
   localparam int INSIDE_BITS = 8;

   localparam logic [DEPTH_BITS-1:0] SLICE_RESET = DEPTH_BITS'(8388608);
   localparam logic [INSIDE_BITS-1:0] INSIDE_ON = 8'hFF;
   localparam logic [INSIDE_BITS-1:0] INSIDE_OFF = 8'h00;

   typedef struct packed {
      logic [DEPTH_BITS-1:0] depth;
      logic                  last_layer;
   } req_type;

   typedef struct packed {
      logic [DEPTH_BITS-1:0]  sorted_depth;
      logic [INSIDE_BITS-1:0] inside_res;
      logic                   overflow;
      logic                   last_result;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic insert;
      logic classify;
      logic emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic rsp_free;
      logic emit_last;
   } status_type;

endpackage

FILE: hw/rtl/dls_datapath.sv
module dls_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  dls_pkg::cmd_type                cmd,
   output dls_pkg::status_type             status,
   input  dls_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output dls_pkg::rsp_type                rsp_data,
   input  logic                            csr_write_enable,
   input  logic [dls_pkg::DEPTH_BITS-1:0]  csr_write_data
);
   import dls_pkg::*;

   `include "depth_layer_sort_and_slice_defines.svh"

   // sorted layer cells, ascending from cell 0
   logic [DEPTH_BITS-1:0] cell_ff [MAX_LAYERS];
   logic [DEPTH_BITS-1:0] cell_in [MAX_LAYERS];

   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  list_ended_ff, list_ended_in;
   logic                  overflowed_ff, overflowed_in;
   logic                  inside_ff, inside_in;
   logic [DEPTH_BITS-1:0] slice_ff, slice_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic [MAX_LAYERS-1:0] gt;
   logic [MAX_LAYERS-1:0] gt_prev;
   logic [MAX_LAYERS-1:0] below;
   logic                  store_en;
   logic                  take;
   logic                  emit_last;

   assign take      = cmd.insert && !list_ended_ff && (req_data.depth != '0);
   assign store_en  = take && (count_ff < COUNT_BITS'(MAX_LAYERS));
   assign emit_last = (count_ff <= COUNT_BITS'(1));

   // per cell compares against the incoming depth and the slice plane
   always_comb begin
      for (int i = 0; i < MAX_LAYERS; i++) begin
         gt[i]    = (COUNT_BITS'(i) < count_ff) && (cell_ff[i] > req_data.depth);
         below[i] = (COUNT_BITS'(i) < count_ff) && (cell_ff[i] < slice_ff);
      end
      gt_prev = {gt[MAX_LAYERS-2:0], 1'b0};
   end

   always_comb begin
      for (int i = 0; i < MAX_LAYERS; i++) begin
         cell_in[i] = cell_ff[i];
      end
      if (store_en) begin
         // insertion: larger entries move up one cell
         for (int i = 0; i < MAX_LAYERS; i++) begin
            if (gt_prev[i]) begin
               cell_in[i] = (i == 0) ? cell_ff[0] : cell_ff[(i == 0) ? 0 : i-1];
            end else if (gt[i] || (COUNT_BITS'(i) == count_ff)) begin
               cell_in[i] = req_data.depth;
            end
         end
      end else if (cmd.emit) begin
         // smallest leaves from cell 0
         for (int i = 0; i < MAX_LAYERS - 1; i++) begin
            cell_in[i] = cell_ff[i+1];
         end
      end
   end

   always_comb begin
      count_in      = count_ff;
      list_ended_in = list_ended_ff;
      overflowed_in = overflowed_ff;
      inside_in     = inside_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      slice_in      = csr_write_enable ? csr_write_data : slice_ff;

      if (cmd.insert && !list_ended_ff && (req_data.depth == '0)) begin
         list_ended_in = 1'b1;
      end
      if (store_en) begin
         count_in = count_ff + COUNT_BITS'(1);
      end else if (take) begin
         overflowed_in = 1'b1;
      end

      if (cmd.classify) begin
         inside_in = ^below;
      end

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.sorted_depth = (count_ff == '0) ? '0 : cell_ff[0];
         rsp_data_in.inside_res   = inside_ff ? INSIDE_ON : INSIDE_OFF;
         rsp_data_in.overflow     = overflowed_ff;
         rsp_data_in.last_result  = emit_last;
         if (count_ff != '0) begin
            count_in = count_ff - COUNT_BITS'(1);
         end
         if (emit_last) begin
            list_ended_in = 1'b0;
            overflowed_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         list_ended_ff <= 1'b0;
         overflowed_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         slice_ff      <= SLICE_RESET;
      end else begin
         count_ff      <= count_in;
         list_ended_ff <= list_ended_in;
         overflowed_ff <= overflowed_in;
         rsp_valid_ff  <= rsp_valid_in;
         slice_ff      <= slice_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_LAYERS; i++) begin
         cell_ff[i] <= cell_in[i];
      end
      inside_ff   <= inside_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign status    = '{rsp_free: !rsp_valid_ff || rsp_ready, emit_last: emit_last};
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `DLS_ASSERT_NOW(a_count_bound, clock, reset, 1'b1,
      count_ff <= COUNT_BITS'(MAX_LAYERS), "layer count beyond store size")
   `DLS_ASSERT_NEXT(a_emit_drains, clock, reset, cmd.emit && emit_last,
      (count_ff == '0) && !overflowed_ff && !list_ended_ff,
      "pixel state not cleared after final word")
   `DLS_ASSERT_NEXT(a_store_counts, clock, reset, store_en && !cmd.emit,
      count_ff == $past(count_ff) + COUNT_BITS'(1), "stored layer not counted")

endmodule

FILE: hw/rtl/dls_controller.sv
module dls_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_last_layer,
   input  dls_pkg::status_type status,
   output dls_pkg::cmd_type    cmd
);
   import dls_pkg::*;

   `include "depth_layer_sort_and_slice_defines.svh"

   localparam logic [1:0] ST_COLLECT  = 2'd0;
   localparam logic [1:0] ST_CLASSIFY = 2'd1;
   localparam logic [1:0] ST_EMIT     = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       accept;

   assign req_ready = (state_ff == ST_COLLECT);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      cmd.insert   = 1'b0;
      cmd.classify = 1'b0;
      cmd.emit     = 1'b0;
      unique case (state_ff)
         ST_COLLECT: begin
            cmd.insert = accept;
            if (accept && req_last_layer) begin
               state_in = ST_CLASSIFY;
            end
         end
         ST_CLASSIFY: begin
            cmd.classify = 1'b1;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.rsp_free) begin
               cmd.emit = 1'b1;
               if (status.emit_last) begin
                  state_in = ST_COLLECT;
               end
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
      end else begin
         state_ff <= state_in;
      end
   end

   `DLS_ASSERT_NEXT(a_close_classifies, clock, reset, accept && req_last_layer,
      cmd.classify && !req_ready, "closing word not followed by classify")
   `DLS_ASSERT_NEXT(a_classify_emits, clock, reset, cmd.classify,
      state_ff == ST_EMIT, "classify not followed by emit")
   `DLS_ASSERT_NOW(a_emit_has_room, clock, reset, cmd.emit, status.rsp_free,
      "word emitted over a held result")

endmodule

FILE: hw/rtl/depth_layer_sort_and_slice.sv
// Depth layer sort and slice: a pixel arrives as a run of request words, one
// layer depth each, closed by last_layer. Depths are kept in a row of 16
// sorted cells; each stored depth is inserted in the cycle it is accepted.
// A zero depth ends the pixel's list and later layers are ignored; valid
// depths past 16 are dropped and flag overflow. After the closing word the
// classify strobe, high for a single cycle, classifies the pixel
// (parity of depths strictly below slice_depth, from csr_write_data) and then
// the depths leave in ascending order, one response word per cycle while
// rsp_ready is high, the smallest shifted out of cell 0. An empty pixel gives
// one word of depth 0. The request side is held off from the closing word
// until the last response word is loaded into the output register.
module depth_layer_sort_and_slice (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  dls_pkg::req_type               req_data,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output dls_pkg::rsp_type               rsp_data,
   // slice depth register
   input  logic                           csr_write_enable,
   input  logic [dls_pkg::DEPTH_BITS-1:0] csr_write_data
);
   import dls_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencing: collect, classify, emit
   dls_controller u_controller (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_last_layer (req_data.last_layer),
      .status         (status),
      .cmd            (cmd)
   );

   // sorted cells, pixel flags, slice register and output register
   dls_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

endmodule

FILE: tb/layer_sort_checker.sv
module layer_sort_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  dls_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  dls_pkg::rsp_type rsp_data,
   input  logic             csr_write_enable,
   input  logic [23:0]      csr_write_data,
   output int               fail_count,
   output int               words_due
);
   import dls_pkg::*;

   localparam int REPORT_LIMIT = 10;

   logic [DEPTH_BITS-1:0] kept_depths [MAX_LAYERS];
   int unsigned           kept_count;
   logic                  list_closed;
   logic                  dropped;
   logic [DEPTH_BITS-1:0] slice_level;
   rsp_type               sorted_due [$];
   int                    reported;

   // depths are kept in ascending order as they arrive
   function automatic void keep_depth(input logic [DEPTH_BITS-1:0] d);
      int unsigned k;
      k = kept_count;
      while (k > 0 && kept_depths[k - 1] > d) begin
         kept_depths[k] = kept_depths[k - 1];
         k--;
      end
      kept_depths[k] = d;
      kept_count++;
   endfunction

   function automatic void close_pixel();
      int unsigned below;
      int unsigned i;
      rsp_type     r;
      below = 0;
      for (i = 0; i < kept_count; i++) begin
         if (kept_depths[i] < slice_level) below++;
      end
      if (kept_count == 0) begin
         r.sorted_depth = '0;
         r.inside_res = INSIDE_OFF;
         r.overflow = 1'b0;
         r.last_result = 1'b1;
         sorted_due.insert(sorted_due.size(), r);
      end else begin
         for (i = 0; i < kept_count; i++) begin
            r.sorted_depth = kept_depths[i];
            r.inside_res = below[0] ? INSIDE_ON : INSIDE_OFF;
            r.overflow = dropped;
            r.last_result = (i + 1 == kept_count);
            sorted_due.insert(sorted_due.size(), r);
         end
      end
      kept_count = 0;
      list_closed = 1'b0;
      dropped = 1'b0;
   endfunction

   function automatic void take_layer(input req_type w);
      if (!list_closed) begin
         if (w.depth == '0) list_closed = 1'b1;
         else if (kept_count < MAX_LAYERS) keep_depth(w.depth);
         else dropped = 1'b1;
      end
      if (w.last_layer) close_pixel();
   endfunction

   function automatic void check_word(input rsp_type got);
      rsp_type want;
      if (sorted_due.size() == 0) begin
         fail_count++;
         if (reported < REPORT_LIMIT) begin
            reported++;
            $display("unexpected rsp word: depth %0d inside %0d overflow %0b last %0b",
                     got.sorted_depth, got.inside_res, got.overflow, got.last_result);
         end
      end else begin
         want = sorted_due.pop_front();
         if (got.sorted_depth !== want.sorted_depth || got.inside_res !== want.inside_res ||
             got.overflow !== want.overflow || got.last_result !== want.last_result) begin
            fail_count++;
            if (reported < REPORT_LIMIT) begin
               reported++;
               $display("rsp mismatch: expected depth %0d inside %0d overflow %0b last %0b",
                        want.sorted_depth, want.inside_res, want.overflow, want.last_result);
               $display("              actual   depth %0d inside %0d overflow %0b last %0b",
                        got.sorted_depth, got.inside_res, got.overflow, got.last_result);
            end
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         kept_count = 0;
         list_closed = 1'b0;
         dropped = 1'b0;
         slice_level = SLICE_RESET;
         sorted_due.delete();
         fail_count = 0;
         reported = 0;
      end else begin
         if (csr_write_enable) slice_level = csr_write_data;
         if (req_valid && req_ready) take_layer(req_data);
         if (rsp_valid && rsp_ready) check_word(rsp_data);
      end
      words_due = sorted_due.size();
   end

endmodule

FILE: tb/depth_layer_sort_and_slice_tb.sv
module depth_layer_sort_and_slice_tb;
   import dls_pkg::*;

   localparam int PHASE_WORDS = 85;     // request words per random phase
   localparam int HOLD_CYCLES = 300;    // long rsp hold-off, fills the block
   localparam int DRAIN_CYCLES = 40;    // settle wait once no rsp words are due
   localparam int CYCLE_LIMIT = 200000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_write_enable;
   logic [23:0] csr_write_data;

   int fail_count;
   int words_due;

   // traffic shaping, written by the stimulus process only
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_asked = 0;
   // owned by the receiver process
   int hold_served = 0;
   int hold_left = 0;

   int cycle_count = 0;
   int words_sent = 0;
   logic [23:0] slice_now;

   depth_layer_sort_and_slice dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   layer_sort_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .words_due        (words_due)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // receiver: random stalls, plus a long hold-off whenever one is asked for
   always @(negedge clock) begin
      if (hold_served != hold_asked) begin
         hold_served = hold_asked;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // one request word; valid stays up until the word is taken
   task automatic send_word(input logic [23:0] depth, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data.depth <= depth;
      req_data.last_layer <= last;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      words_sent++;
   endtask

   // depth mix: list ends, extremes, tiny values and values around the slice
   function automatic logic [23:0] any_depth();
      case ($urandom_range(11))
         0:       any_depth = '0;
         1:       any_depth = 24'hFFFFFF;
         2:       any_depth = 24'($urandom_range(15, 1));
         3, 4:    any_depth = slice_now + 24'($urandom_range(4)) - 24'd2;
         default: any_depth = 24'($urandom);
      endcase
   endfunction

   // a pixel is mostly a few layers, sometimes one, sometimes past the store
   task automatic send_pixel();
      int layers;
      int pick;
      pick = $urandom_range(99);
      if (pick < 8) layers = $urandom_range(20, 15);
      else if (pick < 25) layers = 1;
      else layers = $urandom_range(7, 2);
      for (int k = 0; k < layers; k++) send_word(any_depth(), k == layers - 1);
   endtask

   // slice register only changes with the block drained and quiet
   task automatic set_slice(input logic [23:0] level);
      req_valid <= 1'b0;
      while (words_due != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= level;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      slice_now = level;
   endtask

   task automatic run_phase(input logic [23:0] level, input int idle, input int stall,
                            input bit hold_off);
      int goal;
      set_slice(level);
      send_idle_pct = idle;
      rsp_stall_pct = stall;
      if (hold_off) hold_asked++;
      goal = words_sent + PHASE_WORDS;
      while (words_sent < goal) send_pixel();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      slice_now = SLICE_RESET;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed pixels, slice still at its reset value
      send_word(24'd0, 1'b1);              // empty pixel, zero on the closing word
      send_word(24'hFFFFFF, 1'b0);         // extremes, out of order
      send_word(24'd1, 1'b1);
      send_word(SLICE_RESET, 1'b1);        // equal to the slice is not below it
      send_word(24'd5, 1'b0);              // zero mid-run, later layer ignored
      send_word(24'd0, 1'b0);
      send_word(24'd7, 1'b1);
      send_word(24'd3, 1'b0);              // equal depths, then a closing zero
      send_word(24'd3, 1'b0);
      send_word(24'd0, 1'b1);
      // seventeen descending layers: full reversal and one dropped depth
      for (int k = 17; k >= 1; k--) send_word(24'(k * 65537), k == 1);

      // random phases; the first one also holds off rsp to back up req
      run_phase(24'hFFFFFF, 0, 0, 1'b1);
      run_phase(24'd0, 55, 0, 1'b0);
      run_phase(24'($urandom), 0, 55, 1'b0);
      run_phase(SLICE_RESET, 28, 28, 1'b0);

      req_valid <= 1'b0;
      while (words_due != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/dls_pkg.sv
hw/rtl/dls_datapath.sv
hw/rtl/dls_controller.sv
hw/rtl/depth_layer_sort_and_slice.sv
tb/layer_sort_checker.sv
tb/depth_layer_sort_and_slice_tb.sv
